// File: design/swtp_pkg.sv
package swtp_pkg;

  // default table depth
  localparam int MaxEntriesDflt = 16;

  // boundary words walked per entry
  localparam logic [3:0] PATTERN_COUNT = 4'd9;

  // smallest size with room for a word at offset zero is five
  localparam logic [15:0] WORD_BYTES = 16'd4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } swtp_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK
  } swtp_state_e;

  typedef enum logic [1:0] {
    STEP_EMIT_EXH,
    STEP_EMIT_CASE,
    STEP_NEXT_PAT,
    STEP_NEXT_ENTRY
  } swtp_step_e;

  typedef struct packed {
    swtp_op_e    opcode;
    logic [3:0]  entry_index;
    logic [31:0] entry_code;
    logic [15:0] entry_size;
  } swtp_in_t;

  typedef struct packed {
    logic        exhausted;
    logic [31:0] request_code;
    logic [15:0] buffer_length;
    logic [15:0] pattern_offset;
    logic [31:0] pattern_word;
  } swtp_out_t;

  typedef struct packed {
    logic [31:0] code;
    logic [15:0] size;
  } swtp_entry_t;

  function automatic logic [31:0] boundary_word(input logic [3:0] idx);
    logic [31:0] w;
    case (idx)
      4'd0:    w = 32'h0fff_ffff;
      4'd1:    w = 32'h1000_0000;
      4'd2:    w = 32'h1fff_ffff;
      4'd3:    w = 32'h2000_0000;
      4'd4:    w = 32'h3fff_ffff;
      4'd5:    w = 32'h4000_0000;
      4'd6:    w = 32'h7fff_ffff;
      4'd7:    w = 32'h8000_0000;
      4'd8:    w = 32'hffff_ffff;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage

// File: design/sliding_word_test_pattern_sequencer_unit.sv
// channel  | valid        | stall        | payload                 | moves
// ---------+--------------+--------------+-------------------------+------------------------------
// in       | in_valid_i   | in_stall_o   | in_word_i  (swtp_in_t)  | load or next word
// out      | out_valid_o  | out_stall_i  | out_word_o (swtp_out_t) | one word per next item
// cfg      | cfg_we_i     | -            | cfg_data_i [4:0]        | entry_count, no wait
//
// a load word is taken straight from the idle state and gives no result
// a next word makes one walk step per cycle on the shared offset/size
// compare, plus a table read state (ST_FETCH) for each entry advanced over;
// a plain case or exhaustion is emitted from the walk state, skipping a
// pattern stays in it and moving to the next entry passes through ST_FETCH
// reset clears cursors, entry count and output valid; the table is not cleared
// a stalled output holds the result in the walk state until the register frees
module sliding_word_test_pattern_sequencer_unit #(
  parameter int MAX_ENTRIES = swtp_pkg::MaxEntriesDflt
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  swtp_pkg::swtp_in_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output swtp_pkg::swtp_out_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [4:0]         cfg_data_i
);
  import swtp_pkg::*;

  // table index, cursor able to hold MAX_ENTRIES, compare width for the count
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CUR_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CUR_W > 5) ? CUR_W : 5;

  swtp_state_e state_q, state_d;
  swtp_step_e  step;

  logic [4:0]       entry_count_q;
  logic [CUR_W-1:0] ent_cur_q, ent_cur_d;
  logic [3:0]       pat_cur_q, pat_cur_d;
  logic [15:0]      off_cur_q, off_cur_d;

  logic        out_valid_q, out_valid_d;
  swtp_out_t   out_word_q;

  logic        tbl_we;
  swtp_entry_t tbl_wdata;
  swtp_entry_t tbl_rdata;

  logic [CMP_W-1:0] count_eff;
  logic             entry_live;
  logic             has_room;
  logic             out_free;
  logic             out_load;
  logic             take_in;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  // request table, read at the entry cursor every cycle
  assign tbl_wdata = '{code: in_word_i.entry_code, size: in_word_i.entry_size};

  swtp_table #(
    .DEPTH(MAX_ENTRIES),
    .IDX_W(IDX_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(IDX_W'(in_word_i.entry_index)),
    .wdata_i(tbl_wdata),
    .raddr_i(ent_cur_q[IDX_W-1:0]),
    .rdata_o(tbl_rdata)
  );

  // counts above the table depth act as the full table
  assign count_eff  = (CMP_W'(entry_count_q) > CMP_W'(MAX_ENTRIES)) ?
                      CMP_W'(MAX_ENTRIES) : CMP_W'(entry_count_q);
  assign entry_live = CMP_W'(ent_cur_q) < count_eff;

  // the shared compare: does the offset still fit a whole word in the buffer
  assign has_room = (tbl_rdata.size > WORD_BYTES) &&
                    (off_cur_q < (tbl_rdata.size - WORD_BYTES));

  assign out_free = !out_valid_q || !out_stall_i;
  assign take_in  = in_valid_i && !in_stall_o;

  // one iteration of the walk, decided from the current cursors
  always_comb begin
    if (!entry_live) begin
      step = STEP_EMIT_EXH;
    end else if (pat_cur_q < PATTERN_COUNT) begin
      step = has_room ? STEP_EMIT_CASE : STEP_NEXT_PAT;
    end else begin
      step = STEP_NEXT_ENTRY;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_in && in_word_i.opcode == OP_NEXT) begin
          state_d = ST_WALK;
        end
      end
      ST_FETCH: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        case (step)
          STEP_EMIT_EXH, STEP_EMIT_CASE: begin
            if (out_free) begin
              state_d = ST_IDLE;
            end
          end
          STEP_NEXT_PAT:   state_d = ST_WALK;
          STEP_NEXT_ENTRY: state_d = ST_FETCH;
          default:         state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    // slots beyond the table are dropped
    tbl_we     = (state_q == ST_IDLE) && in_valid_i && (in_word_i.opcode == OP_LOAD) &&
                 (32'(in_word_i.entry_index) < MAX_ENTRIES);
    out_load   = (state_q == ST_WALK) && out_free &&
                 ((step == STEP_EMIT_EXH) || (step == STEP_EMIT_CASE));
  end

  // cursor updates; exhaustion leaves them in place so a larger count resumes
  always_comb begin
    ent_cur_d = ent_cur_q;
    pat_cur_d = pat_cur_q;
    off_cur_d = off_cur_q;
    if (state_q == ST_WALK) begin
      case (step)
        STEP_EMIT_CASE: begin
          if (out_free) begin
            off_cur_d = off_cur_q + 16'd1;
          end
        end
        STEP_NEXT_PAT: begin
          pat_cur_d = pat_cur_q + 4'd1;
          off_cur_d = '0;
        end
        STEP_NEXT_ENTRY: begin
          ent_cur_d = ent_cur_q + CUR_W'(1);
          pat_cur_d = '0;
          off_cur_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ent_cur_q <= '0;
      pat_cur_q <= '0;
      off_cur_q <= '0;
    end else begin
      state_q   <= state_d;
      ent_cur_q <= ent_cur_d;
      pat_cur_q <= pat_cur_d;
      off_cur_q <= off_cur_d;
    end
  end

  // output register
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (step == STEP_EMIT_EXH) begin
        out_word_q <= '{exhausted: 1'b1, default: '0};
      end else begin
        out_word_q <= '{exhausted:      1'b0,
                        request_code:   tbl_rdata.code,
                        buffer_length:  tbl_rdata.size,
                        pattern_offset: off_cur_q,
                        pattern_word:   boundary_word(pat_cur_q)};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // a result only appears out of the walk state
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> state_q == ST_WALK)
    else $error("result loaded outside walk");

  a_fetch_then_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |=> state_q == ST_WALK)
    else $error("table read not followed by walk step");

  a_pattern_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pat_cur_q <= PATTERN_COUNT)
    else $error("pattern cursor past last boundary word");

  a_entry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ent_cur_q) <= MAX_ENTRIES)
    else $error("entry cursor past table");

  a_exhausted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.exhausted |->
      out_word_o.request_code == '0 && out_word_o.buffer_length == '0 &&
      out_word_o.pattern_offset == '0 && out_word_o.pattern_word == '0)
    else $error("exhausted result carries data");

endmodule

// File: design/swtp_table.sv
module swtp_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  swtp_pkg::swtp_entry_t wdata_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output swtp_pkg::swtp_entry_t rdata_o
);
  import swtp_pkg::*;

  swtp_entry_t mem [DEPTH];
  swtp_entry_t rdata_q;

  // entries are undefined until loaded
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, refreshed every cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
